FILE: src/buddy_memory_allocator_top_assert.svh
// assertion macros shared by the buddy allocator rtl
// no dependencies; taken in by the files that check their own logic
`ifndef BUDDY_MEMORY_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_MEMORY_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define BMA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("buddy allocator assertion failed");
// next-cycle implication, checked out of reset
`define BMA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("buddy allocator assertion failed");
`else
`define BMA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BMA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/bma_pkg.sv
// types, constants and helper functions of the buddy allocator
// no dependencies; used by bma_ctrl and buddy_memory_allocator_top
package bma_pkg;

    localparam int MEM_SIZE   = 1024;
    localparam int MIN_BLOCK  = 32;
    localparam int LOG_MEM    = $clog2(MEM_SIZE);
    localparam int LEAF_LEVEL = $clog2(MEM_SIZE / MIN_BLOCK);
    localparam int NODE_CNT   = 2 ** (LEAF_LEVEL + 1) - 1;
    localparam int NODE_AW    = $clog2(NODE_CNT + 1);
    localparam int LVL_W      = $clog2(LEAF_LEVEL + 1);
    localparam int POS_W      = (LEAF_LEVEL > 0) ? LEAF_LEVEL : 1;
    localparam int REQ_W      = 11;
    localparam int OFF_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int STAT_W     = 2;
    localparam int NODE_W     = 2;

    typedef logic [NODE_AW-1:0] node_idx_t;
    typedef logic [LVL_W-1:0]   lvl_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [OFF_W-1:0]   off_t;
    typedef logic [SIZE_W-1:0]  blk_size_t;
    typedef logic [REQ_W-1:0]   req_t;

    typedef enum logic [NODE_W-1:0] {
        NODE_ABSENT = 2'd0,
        NODE_FREE   = 2'd1,
        NODE_SPLIT  = 2'd2,
        NODE_ALLOC  = 2'd3
    } node_st_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_NOT_ALLOC = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t cmd;
        req_t req;
        off_t off;
    } cmd_word_t;

    typedef struct packed {
        status_t   status;
        off_t      offset;
        blk_size_t size;
    } res_word_t;

    typedef struct packed {
        logic      we;
        node_idx_t waddr;
        node_st_t  wdata;
        logic      re;
        node_idx_t raddr;
    } mem_req_t;

    // deepest level whose block still holds the rounded request
    function automatic lvl_t fit_level(input req_t req);
        lvl_t lvl;
        lvl = '0;
        for (int l = 1; l <= LEAF_LEVEL; l++) begin
            if ((MEM_SIZE >> l) >= int'(req)) begin
                lvl = lvl_t'(l);
            end
        end
        return lvl;
    endfunction

    // heap index of the node at a level and position
    function automatic node_idx_t node_at(input lvl_t lvl, input pos_t pos);
        return node_idx_t'((32'd1 << lvl) - 32'd1) + node_idx_t'(pos);
    endfunction

    // start offset of the node at a level and position
    function automatic off_t offset_at(input lvl_t lvl, input pos_t pos);
        return off_t'(32'(pos) << (LOG_MEM - int'(lvl)));
    endfunction

    function automatic blk_size_t size_at(input lvl_t lvl);
        return blk_size_t'(MEM_SIZE >> lvl);
    endfunction

    function automatic off_t off_mask(input lvl_t lvl);
        return off_t'((MEM_SIZE >> lvl) - 1);
    endfunction

endpackage

FILE: src/bma_node_ram.sv
// single-port-write, single-port-read synchronous ram for the node states
// generic, no package dependency; read data registered
module bma_node_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bma_ctrl.sv
// sequencer of the buddy allocator: clearing pass, placement scan,
// split writes, free descent and buddy merge; depends on bma_pkg
module bma_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  bma_pkg::cmd_word_t  cmd_in,
    output logic                s_ready,
    output logic                res_valid,
    input  logic                res_ready,
    output bma_pkg::res_word_t  res,
    output bma_pkg::mem_req_t   mem,
    input  logic [bma_pkg::NODE_W-1:0] rdata
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_SPLIT_W,
        ST_RIGHT_W,
        ST_ALLOC_W,
        ST_F_RD,
        ST_F_CHK,
        ST_F_WFREE,
        ST_M_RD,
        ST_M_CHK,
        ST_M_W_CUR,
        ST_M_W_BUD,
        ST_M_W_PAR,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    bma_pkg::node_idx_t clr_reg, clr_next;
    bma_pkg::off_t      tgt_off_reg, tgt_off_next;
    bma_pkg::lvl_t      tgt_lvl_reg, tgt_lvl_next;
    bma_pkg::lvl_t      lvl_reg, lvl_next;
    bma_pkg::pos_t      pos_reg, pos_next;
    bma_pkg::node_idx_t node_reg, node_next;
    logic               rd_vld_reg, rd_vld_next;
    bma_pkg::node_idx_t rd_node_reg, rd_node_next;
    bma_pkg::lvl_t      rd_lvl_reg, rd_lvl_next;
    bma_pkg::off_t      rd_off_reg, rd_off_next;
    logic               found_reg, found_next;
    bma_pkg::node_idx_t best_node_reg, best_node_next;
    bma_pkg::lvl_t      best_lvl_reg, best_lvl_next;
    bma_pkg::off_t      best_off_reg, best_off_next;
    bma_pkg::res_word_t res_reg, res_next;

    bma_pkg::node_st_t  rd_st;
    logic               take_cand;
    bma_pkg::req_t      req_round;
    bma_pkg::node_idx_t scan_node;
    bma_pkg::node_idx_t first_child;
    bma_pkg::node_idx_t buddy;
    bma_pkg::node_idx_t parent;
    logic               child_bit;
    logic               aligned;
    bma_pkg::res_word_t merge_res;

    assign rd_st     = bma_pkg::node_st_t'(rdata);
    assign req_round = (cmd_in.req < bma_pkg::req_t'(bma_pkg::MIN_BLOCK)) ?
                       bma_pkg::req_t'(bma_pkg::MIN_BLOCK) : cmd_in.req;
    assign scan_node = bma_pkg::node_at(lvl_reg, pos_reg);
    assign first_child = bma_pkg::node_idx_t'({node_reg, 1'b0} +
                                              {{bma_pkg::NODE_AW{1'b0}}, 1'b1});
    assign buddy     = node_reg[0] ? node_reg + bma_pkg::node_idx_t'(1)
                                   : node_reg - bma_pkg::node_idx_t'(1);
    assign parent    = (node_reg - bma_pkg::node_idx_t'(1)) >> 1;
    assign child_bit = tgt_off_reg[4'(bma_pkg::LOG_MEM - 1 - int'(lvl_reg))];
    assign aligned   = (tgt_off_reg & bma_pkg::off_mask(lvl_reg)) == '0;

    // free node further left than the best so far, or the first one found
    assign take_cand = rd_vld_reg && (rd_st == bma_pkg::NODE_FREE) &&
                       (!found_reg || (rd_off_reg < best_off_reg));

    always_comb begin
        merge_res.status = bma_pkg::STAT_OK;
        merge_res.offset = tgt_off_reg & ~bma_pkg::off_mask(lvl_reg);
        merge_res.size   = bma_pkg::size_at(lvl_reg);
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        tgt_off_next   = tgt_off_reg;
        tgt_lvl_next   = tgt_lvl_reg;
        lvl_next       = lvl_reg;
        pos_next       = pos_reg;
        node_next      = node_reg;
        rd_vld_next    = 1'b0;
        rd_node_next   = rd_node_reg;
        rd_lvl_next    = rd_lvl_reg;
        rd_off_next    = rd_off_reg;
        found_next     = found_reg | take_cand;
        best_node_next = take_cand ? rd_node_reg : best_node_reg;
        best_lvl_next  = take_cand ? rd_lvl_reg  : best_lvl_reg;
        best_off_next  = take_cand ? rd_off_reg  : best_off_reg;
        res_next       = res_reg;
        mem            = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem.we    = 1'b1;
                mem.waddr = clr_reg;
                mem.wdata = (clr_reg == '0) ? bma_pkg::NODE_FREE : bma_pkg::NODE_ABSENT;
                clr_next  = clr_reg + bma_pkg::node_idx_t'(1);
                if (clr_reg == bma_pkg::node_idx_t'(bma_pkg::NODE_CNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    lvl_next     = '0;
                    pos_next     = '0;
                    node_next    = '0;
                    tgt_off_next = cmd_in.off;
                    found_next   = 1'b0;
                    res_next     = '{bma_pkg::STAT_NO_SPACE, '0, '0};
                    if (cmd_in.cmd == bma_pkg::CMD_FREE) begin
                        state_next = ST_F_RD;
                    end else if (req_round > bma_pkg::req_t'(bma_pkg::MEM_SIZE)) begin
                        state_next = ST_DONE;
                    end else begin
                        tgt_lvl_next = bma_pkg::fit_level(req_round);
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                mem.re       = 1'b1;
                mem.raddr    = scan_node;
                rd_vld_next  = 1'b1;
                rd_node_next = scan_node;
                rd_lvl_next  = lvl_reg;
                rd_off_next  = bma_pkg::offset_at(lvl_reg, pos_reg);
                if (pos_reg == bma_pkg::pos_t'((32'd1 << lvl_reg) - 32'd1)) begin
                    pos_next = '0;
                    if (lvl_reg == tgt_lvl_reg) begin
                        state_next = ST_SCAN_END;
                    end else begin
                        lvl_next = lvl_reg + bma_pkg::lvl_t'(1);
                    end
                end else begin
                    pos_next = pos_reg + bma_pkg::pos_t'(1);
                end
            end
            ST_SCAN_END: begin
                if (found_next) begin
                    node_next      = best_node_next;
                    lvl_next       = best_lvl_next;
                    res_next       = '{bma_pkg::STAT_OK, best_off_next,
                                       bma_pkg::size_at(tgt_lvl_reg)};
                    state_next     = (best_lvl_next < tgt_lvl_reg) ? ST_SPLIT_W : ST_ALLOC_W;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SPLIT_W: begin
                mem.we     = 1'b1;
                mem.waddr  = node_reg;
                mem.wdata  = bma_pkg::NODE_SPLIT;
                state_next = ST_RIGHT_W;
            end
            ST_RIGHT_W: begin
                mem.we     = 1'b1;
                mem.waddr  = first_child + bma_pkg::node_idx_t'(1);
                mem.wdata  = bma_pkg::NODE_FREE;
                node_next  = first_child;
                lvl_next   = lvl_reg + bma_pkg::lvl_t'(1);
                state_next = (lvl_next < tgt_lvl_reg) ? ST_SPLIT_W : ST_ALLOC_W;
            end
            ST_ALLOC_W: begin
                mem.we     = 1'b1;
                mem.waddr  = node_reg;
                mem.wdata  = bma_pkg::NODE_ALLOC;
                state_next = ST_DONE;
            end
            ST_F_RD: begin
                mem.re     = 1'b1;
                mem.raddr  = node_reg;
                state_next = ST_F_CHK;
            end
            ST_F_CHK: begin
                if (rd_st == bma_pkg::NODE_SPLIT &&
                    lvl_reg != bma_pkg::lvl_t'(bma_pkg::LEAF_LEVEL)) begin
                    node_next  = first_child + bma_pkg::node_idx_t'(child_bit);
                    lvl_next   = lvl_reg + bma_pkg::lvl_t'(1);
                    state_next = ST_F_RD;
                end else if (rd_st == bma_pkg::NODE_ALLOC && aligned) begin
                    state_next = ST_F_WFREE;
                end else begin
                    res_next   = '{bma_pkg::STAT_NOT_ALLOC, '0, '0};
                    state_next = ST_DONE;
                end
            end
            ST_F_WFREE: begin
                mem.we     = 1'b1;
                mem.waddr  = node_reg;
                mem.wdata  = bma_pkg::NODE_FREE;
                state_next = ST_M_RD;
            end
            ST_M_RD: begin
                if (lvl_reg == '0) begin
                    res_next   = merge_res;
                    state_next = ST_DONE;
                end else begin
                    mem.re     = 1'b1;
                    mem.raddr  = buddy;
                    state_next = ST_M_CHK;
                end
            end
            ST_M_CHK: begin
                if (rd_st == bma_pkg::NODE_FREE) begin
                    state_next = ST_M_W_CUR;
                end else begin
                    res_next   = merge_res;
                    state_next = ST_DONE;
                end
            end
            ST_M_W_CUR: begin
                mem.we     = 1'b1;
                mem.waddr  = node_reg;
                mem.wdata  = bma_pkg::NODE_ABSENT;
                state_next = ST_M_W_BUD;
            end
            ST_M_W_BUD: begin
                mem.we     = 1'b1;
                mem.waddr  = buddy;
                mem.wdata  = bma_pkg::NODE_ABSENT;
                state_next = ST_M_W_PAR;
            end
            ST_M_W_PAR: begin
                mem.we     = 1'b1;
                mem.waddr  = parent;
                mem.wdata  = bma_pkg::NODE_FREE;
                node_next  = parent;
                lvl_next   = lvl_reg - bma_pkg::lvl_t'(1);
                state_next = ST_M_RD;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
        end
        tgt_off_reg   <= tgt_off_next;
        tgt_lvl_reg   <= tgt_lvl_next;
        lvl_reg       <= lvl_next;
        pos_reg       <= pos_next;
        node_reg      <= node_next;
        rd_node_reg   <= rd_node_next;
        rd_lvl_reg    <= rd_lvl_next;
        rd_off_reg    <= rd_off_next;
        best_node_reg <= best_node_next;
        best_lvl_reg  <= best_lvl_next;
        best_off_reg  <= best_off_next;
        res_reg       <= res_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    `include "buddy_memory_allocator_top_assert.svh"

    `BMA_ASSERT_IMP(a_no_rw_same_node, aclk, aresetn, mem.we && mem.re, mem.waddr != mem.raddr)
    `BMA_ASSERT_IMP(a_idle_mem_quiet, aclk, aresetn, state_reg == ST_IDLE, !mem.we && !mem.re)
    `BMA_ASSERT_IMP(a_ok_has_size, aclk, aresetn,
                    res_valid && res.status == bma_pkg::STAT_OK,
                    res.size >= bma_pkg::blk_size_t'(bma_pkg::MIN_BLOCK))

endmodule

FILE: src/buddy_memory_allocator_top.sv
// top level of the binary buddy allocator: stream ports, output register
// depends on bma_pkg, bma_node_ram and bma_ctrl
//
// usage
// - one request word in on s_*: s_tuser is the command (0 allocate,
//   1 free), s_tdata carries request_size and block_offset
// - exactly one result word out on m_*: m_tuser is the status (0 ok,
//   1 no space, 2 block not allocated), m_tdata offset and size
// - one request at a time: s_tready is high only while the sequencer is idle
// - allocate of a block at tree level l: a scan of 2^(l+1)-1 node reads
//   (one per cycle), then split writes down from the level f of the free
//   block found and one write that marks the block allocated
// - free: a read and a check per level of descent, one write, then per
//   merged level a buddy read, a check and three writes
// - the node memory's single read and single write port set the pace of these steps
// - after reset the node memory is swept once with s_tready low,
//   leaving the whole memory as one free block
// - a stalled receiver holds the result in the output register; the
//   sequencer accepts the next request meanwhile and only waits if a second
//   result is ready before the first is taken
module buddy_memory_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [10:0] request_size, [20:11] block_offset, rest zero
    input  logic        s_tuser,  // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [9:0] result_offset, [20:10] result_size, rest zero
    output logic [1:0]  m_tuser   // [1:0] status
);

    bma_pkg::cmd_word_t cmd_in;
    bma_pkg::res_word_t res;
    bma_pkg::mem_req_t  mem;
    logic [bma_pkg::NODE_W-1:0] rdata;
    logic               start;
    logic               res_valid;
    logic               res_ready;

    logic               m_tvalid_reg, m_tvalid_next;
    bma_pkg::res_word_t out_reg, out_next;

    // unpack the request word
    assign cmd_in.cmd = bma_pkg::cmd_t'(s_tuser);
    assign cmd_in.req = s_tdata[10:0];
    assign cmd_in.off = s_tdata[20:11];
    assign start      = s_tvalid && s_tready;

    // node state memory, one entry per tree node in heap order
    bma_node_ram #(
        .WIDTH (bma_pkg::NODE_W),
        .DEPTH (2 ** bma_pkg::NODE_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    bma_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cmd_in    (cmd_in),
        .s_ready   (s_tready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem       (mem),
        .rdata     (rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg.size, out_reg.offset};
    assign m_tuser  = out_reg.status;

    `include "buddy_memory_allocator_top_assert.svh"

    // the sequencer must be busy right after taking a request
    `BMA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the binary buddy allocator: a model of the
// node tree predicts every reply; depends on bma_pkg and buddy_memory_allocator_top
module tb;
    import bma_pkg::*;

    // model of the node tree plus the replies still owed by the block
    class buddy_tree_checker;
        node_st_t  tree [NODE_CNT];
        res_word_t pending_replies [$];
        off_t      live_blocks [$];
        int        fault_count;
        int        found_off;
        int        found_size;

        function new();
            foreach (tree[i]) tree[i] = NODE_ABSENT;
            tree[0] = NODE_FREE;
            fault_count = 0;
        endfunction

        // depth-first, left-first placement, splitting free blocks on the way down
        function bit place_block(int idx, int base, int span, int want);
            int half;
            if (idx >= NODE_CNT) return 1'b0;
            if (tree[idx] == NODE_ALLOC || tree[idx] == NODE_ABSENT) return 1'b0;
            half = span / 2;
            if (half < want) begin
                if (tree[idx] == NODE_SPLIT) return 1'b0;
                tree[idx]  = NODE_ALLOC;
                found_off  = base;
                found_size = span;
                return 1'b1;
            end
            if (2 * idx + 2 >= NODE_CNT) return 1'b0;
            if (tree[idx] == NODE_FREE) begin
                tree[idx]         = NODE_SPLIT;
                tree[2 * idx + 1] = NODE_FREE;
                tree[2 * idx + 2] = NODE_FREE;
            end
            if (place_block(2 * idx + 1, base, half, want)) return 1'b1;
            return place_block(2 * idx + 2, base + half, half, want);
        endfunction

        // called once per accepted request word
        function void note_request(cmd_t cmd, req_t req, off_t target);
            res_word_t reply;
            int want, idx, base, span, half, depth, cur, buddy;
            int path_idx [16];
            int path_off [16];
            int path_size [16];
            reply.status = STAT_OK;
            reply.offset = '0;
            reply.size   = '0;
            if (cmd == CMD_ALLOC) begin
                want = int'(req);
                if (want < MIN_BLOCK) want = MIN_BLOCK;
                if (want > MEM_SIZE || !place_block(0, 0, MEM_SIZE, want)) begin
                    reply.status = STAT_NO_SPACE;
                end else begin
                    reply.offset = off_t'(found_off);
                    reply.size   = blk_size_t'(found_size);
                    live_blocks.push_back(off_t'(found_off));
                end
            end else begin
                idx = 0; base = 0; span = MEM_SIZE; depth = 0;
                forever begin
                    path_idx[depth]  = idx;
                    path_off[depth]  = base;
                    path_size[depth] = span;
                    if (tree[idx] != NODE_SPLIT) break;
                    half = span / 2;
                    if (int'(target) < base + half) begin
                        idx = 2 * idx + 1;
                    end else begin
                        idx  = 2 * idx + 2;
                        base = base + half;
                    end
                    span = half;
                    depth++;
                end
                if (tree[idx] != NODE_ALLOC || base != int'(target)) begin
                    reply.status = STAT_NOT_ALLOC;
                end else begin
                    tree[idx] = NODE_FREE;
                    // merge with free buddies as far up as they go
                    while (depth > 0) begin
                        cur   = path_idx[depth];
                        buddy = (cur % 2 == 1) ? cur + 1 : cur - 1;
                        if (buddy >= NODE_CNT || tree[buddy] != NODE_FREE) break;
                        tree[cur]   = NODE_ABSENT;
                        tree[buddy] = NODE_ABSENT;
                        depth--;
                        tree[path_idx[depth]] = NODE_FREE;
                    end
                    reply.offset = off_t'(path_off[depth]);
                    reply.size   = blk_size_t'(path_size[depth]);
                    foreach (live_blocks[i]) begin
                        if (live_blocks[i] == target) begin
                            live_blocks.delete(i);
                            break;
                        end
                    end
                end
            end
            pending_replies.push_back(reply);
        endfunction

        function void note_fault(string msg);
            fault_count++;
            if (fault_count <= 10) $display("tb: %0t %s", $time, msg);
        endfunction

        // called once per accepted result word
        function void check_result(status_t st, off_t offset, blk_size_t size);
            res_word_t want;
            if (pending_replies.size() == 0) begin
                note_fault($sformatf("reply with nothing owed: status %0d offset %0d size %0d",
                                     st, offset, size));
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.status || offset !== want.offset || size !== want.size) begin
                note_fault($sformatf("reply mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.status, want.offset, want.size,
                                     st, offset, size));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [10:0] request_size, [20:11] block_offset, rest zero
    logic        s_tuser;   // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [9:0] result_offset, [20:10] result_size, rest zero
    logic [1:0]  m_tuser;   // [1:0] status

    buddy_tree_checker sb;

    buddy_memory_allocator_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop, far beyond the slowest clean run
    initial begin
        #40_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // receiver: ready in runs, mostly short stalls, a few long ones and
    // now and then a long steady stretch with no stall at all
    initial begin : rx_ready
        int run_left;
        int pick;
        bit level;
        m_tready = 1'b0;
        run_left = 0;
        level    = 1'b0;
        forever begin
            @(negedge aclk);
            if (run_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    level    = 1'b1;
                    run_left = $urandom_range(300, 2000);
                end else if (pick < 50) begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 8);
                end else if (pick < 92) begin
                    level    = 1'b0;
                    run_left = $urandom_range(1, 4);
                end else begin
                    level    = 1'b0;
                    run_left = $urandom_range(20, 150);
                end
            end
            m_tready <= level;
            run_left--;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(status_t'(m_tuser), off_t'(m_tdata[9:0]),
                            blk_size_t'(m_tdata[20:10]));
        end
    end

    // present one request word and hold it until the block takes it
    task automatic send_word(cmd_t cmd, req_t req, off_t target);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, target, req};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, req, target);
    endtask

    // drop valid for a number of cycles
    task automatic tx_idle(int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // hold the sender back until every owed reply is back
    task automatic drain_replies();
        tx_idle(1);
        while (sb.pending_replies.size() != 0) @(negedge aclk);
    endtask

    // sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // request sizes lean small so the tree gets deep and busy
    function automatic req_t pick_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) return req_t'($urandom_range(0, 40));
        if (pick < 70) return req_t'($urandom_range(41, 200));
        if (pick < 92) return req_t'($urandom_range(201, 1024));
        return req_t'($urandom_range(0, 2047));
    endfunction

    initial begin : stimulus
        int n;
        int pick;
        int burst_left;
        int sel;
        off_t target;

        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ALLOC;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: small and zero requests round up to the minimum block
        send_word(CMD_ALLOC, 11'd0, 10'd0);
        send_word(CMD_ALLOC, 11'd31, 10'd0);
        tx_idle(pick_gap());
        send_word(CMD_ALLOC, 11'd33, 10'd0);
        // oversized requests, up to the widest value
        send_word(CMD_ALLOC, 11'd1025, 10'd0);
        send_word(CMD_ALLOC, 11'd2047, 10'h3ff);
        // free, double free, free inside a block, then merging up to the root
        send_word(CMD_FREE, 11'd0, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd16);
        tx_idle(pick_gap());
        send_word(CMD_FREE, 11'd0, 10'd32);
        send_word(CMD_FREE, 11'h7ff, 10'd64);
        // whole memory in one block, then no space left, a bad free and the release
        send_word(CMD_ALLOC, 11'd1024, 10'd0);
        send_word(CMD_ALLOC, 11'd1, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd1023);
        send_word(CMD_FREE, 11'd0, 10'd0);
        // one half, a request just over half and a minimum block, then release both
        send_word(CMD_ALLOC, 11'd512, 10'd0);
        send_word(CMD_ALLOC, 11'd513, 10'd0);
        send_word(CMD_ALLOC, 11'd32, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd512);
        send_word(CMD_FREE, 11'd0, 10'd0);
        // free of a free half's offset, then of the allocated block
        send_word(CMD_ALLOC, 11'd32, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd512);
        send_word(CMD_FREE, 11'd0, 10'd0);

        // let everything settle before the random part
        drain_replies();

        // random part: mostly well-formed alloc/free traffic on live blocks,
        // with some bad frees as noise
        burst_left = 0;
        for (n = 0; n < 1600; n++) begin
            pick = $urandom_range(0, 99);
            if (sb.live_blocks.size() == 0 || pick < 45) begin
                send_word(CMD_ALLOC, pick_size(), off_t'($urandom));
            end else if (pick < 88) begin
                sel    = $urandom_range(0, sb.live_blocks.size() - 1);
                target = sb.live_blocks[sel];
                send_word(CMD_FREE, req_t'($urandom), target);
            end else if (pick < 94) begin
                send_word(CMD_FREE, req_t'($urandom), off_t'($urandom));
            end else begin
                // aligned to the minimum block, often a stale or split offset
                send_word(CMD_FREE, req_t'($urandom),
                          off_t'($urandom_range(0, 31) * MIN_BLOCK));
            end

            // occasionally release everything so the tree merges back to the root
            if ($urandom_range(0, 199) == 0) begin
                while (sb.live_blocks.size() != 0) begin
                    sel = $urandom_range(0, sb.live_blocks.size() - 1);
                    send_word(CMD_FREE, '0, sb.live_blocks[sel]);
                    tx_idle(pick_gap());
                end
            end

            if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 39) == 0) begin
                burst_left = $urandom_range(20, 60);
            end else if ($urandom_range(0, 99) == 0) begin
                drain_replies();
            end else begin
                tx_idle(pick_gap());
            end
        end
        tx_idle(1);

        // wait for the last reply, then watch for strays
        while (sb.pending_replies.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (sb.fault_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/bma_pkg.sv
src/bma_node_ram.sv
src/bma_ctrl.sv
src/buddy_memory_allocator_top.sv
tb/sv/tb.sv
